// ----- design/assert_macros.svh -----
// Assertion helpers for the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/dlts_pkg.sv -----
package dlts_pkg;

  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_WAKEUP      = 3'd1;
  localparam logic [2:0] KIND_SUSPEND     = 3'd2;
  localparam logic [2:0] KIND_SUSP_OTHERS = 3'd3;
  localparam logic [2:0] KIND_DONE        = 3'd4;

  localparam logic [1:0] ST_SUSPENDED = 2'd0;
  localparam logic [1:0] ST_READY     = 2'd1;
  localparam logic [1:0] ST_DELAYING  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_T_HEAD, S_T_WALK, S_T_CUT,
    S_APPEND, S_A_WALK,
    S_W_CHK, S_WAKE, S_D_WALK, S_D_LINK, S_D_PREV,
    S_S_CHK, S_U_WALK, S_S_ADD, S_S_SUM,
    S_SO_D, S_SO_DW, S_SO_R, S_SO_RH, S_SO_RW,
    S_DN, S_FIN, S_OUT
  } fsm_state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         task_id;
    logic signed [15:0] sleep_ticks;
  } cmd_t;

  typedef struct packed {
    logic [3:0] run_task;
    logic       run_valid;
    logic [1:0] slot_state;
  } res_t;

endpackage

// ----- design/dlts_ram.sv -----
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/delta_list_task_scheduler_core.sv -----
`include "assert_macros.svh"
// Delta-list task scheduler core.
// Command channel: present a word on cmd and raise start; the word is taken
// at the rising edge where start is high and busy is low. busy then stays
// high until the result has been shown.
// Result channel: result carries the ready-list head (run_task, run_valid)
// and the state of the addressed slot; done marks it for exactly one cycle.
// The receiver cannot stall, so the word is simply dropped after that cycle.
// Per-slot status, link and delta count live in one synchronous RAM with a
// registered read; list heads live in registers. A walk visits one list node
// per cycle (the read of the next node overlaps the write of the current),
// so a command lasts longer the more list nodes it walks through the RAM
// port; an unknown kind, or a command on empty lists, walks none.
// Reset (rst, synchronous) empties both lists and clears a valid bit per
// slot; a slot never written reads as suspended, null link, zero count, so
// no clearing pass is needed and a command is taken right after reset.
module delta_list_task_scheduler_core
  import dlts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int LW = $clog2(MAX_TASKS + 1);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int EW = 2 + LW + 16;
  localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

  fsm_state_t state, state_next;

  logic [2:0]         kind_q;
  logic [3:0]         id_q;
  logic signed [15:0] sleep_q;
  logic [LW-1:0]      ready_head, delay_head;
  logic [LW-1:0]      cur, prev, tgt, nxt, id_lk;
  logic [15:0]        rem, prev_dl, id_dl;
  logic               in_delay;

  // RAM port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, q;
  logic [1:0]    w_st;
  logic [LW-1:0] w_lk, w_ptr, r_ptr;
  logic [15:0]   w_dl;

  logic [MAX_TASKS-1:0] vld;
  logic                 vld_rd, fwd_rd;
  logic [EW-1:0]        fwd_data, rd;
  logic [1:0]           rd_st;
  logic [LW-1:0]        rd_lk;
  logic [15:0]          rd_dl;

  logic          id_in, rd_lk_nil, rh_nil, dh_nil;
  logic [LW-1:0] id_ptr;
  logic [15:0]   dec, sat;
  logic [16:0]   sum;

  dlts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(q)
  );

  assign waddr = IW'(w_ptr);
  assign raddr = IW'(r_ptr);
  assign wdata = {w_st, w_lk, w_dl};

  // Unwritten slots read as reset value; bypass a write to the read address.
  always_comb begin
    if (fwd_rd) begin
      rd = fwd_data;
    end else if (vld_rd) begin
      rd = q;
    end else begin
      rd = {ST_SUSPENDED, NIL, 16'd0};
    end
  end
  assign rd_st = rd[EW-1 -: 2];
  assign rd_lk = rd[16 +: LW];
  assign rd_dl = rd[15:0];

  assign id_in     = 32'(id_q) < MAX_TASKS;
  assign id_ptr    = LW'(id_q);
  assign rd_lk_nil = rd_lk == NIL;
  assign rh_nil    = ready_head == NIL;
  assign dh_nil    = delay_head == NIL;
  assign dec       = (rd_dl != 16'd0) ? rd_dl - 16'd1 : 16'd0;
  assign sum       = {1'b0, rd_dl} + {1'b0, id_dl};
  assign sat       = sum[16] ? 16'hFFFF : sum[15:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_DISP;
      S_DISP: begin
        case (kind_q)
          KIND_TICK:        state_next = dh_nil ? S_FIN : S_T_HEAD;
          KIND_WAKEUP:      state_next = id_in ? S_W_CHK : S_FIN;
          KIND_SUSPEND:     state_next = id_in ? S_S_CHK : S_FIN;
          KIND_SUSP_OTHERS: state_next = S_SO_D;
          KIND_DONE:        state_next = rh_nil ? S_FIN : S_DN;
          default:          state_next = S_FIN;
        endcase
      end
      S_T_HEAD: begin
        if (dec != 16'd0) state_next = S_FIN;
        else state_next = rd_lk_nil ? S_T_CUT : S_T_WALK;
      end
      S_T_WALK: if (rd_dl != 16'd0 || rd_lk_nil) state_next = S_T_CUT;
      S_T_CUT:  state_next = S_APPEND;
      S_APPEND: state_next = rh_nil ? S_FIN : S_A_WALK;
      S_A_WALK: if (rd_lk_nil) state_next = S_FIN;
      S_W_CHK:  state_next = (rd_st == ST_SUSPENDED) ? S_WAKE : S_FIN;
      S_WAKE: begin
        if (sleep_q < 0) state_next = S_FIN;
        else if (sleep_q == 0) state_next = S_APPEND;
        else state_next = dh_nil ? S_FIN : S_D_WALK;
      end
      S_D_WALK: if (rd_dl > rem || rd_lk_nil) state_next = S_D_LINK;
      S_D_LINK: state_next = (prev == NIL) ? S_FIN : S_D_PREV;
      S_D_PREV: state_next = S_FIN;
      S_S_CHK: begin
        if (rd_st == ST_READY) begin
          state_next = (id_ptr == ready_head) ? S_FIN : S_U_WALK;
        end else if (rd_st == ST_DELAYING) begin
          state_next = (id_ptr == delay_head) ? S_S_ADD : S_U_WALK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_U_WALK: begin
        if (rd_lk == id_ptr) state_next = in_delay ? S_S_ADD : S_FIN;
        else if (rd_lk_nil) state_next = S_FIN;
      end
      S_S_ADD:  state_next = (id_lk == NIL) ? S_FIN : S_S_SUM;
      S_S_SUM:  state_next = S_FIN;
      S_SO_D:   state_next = (cur == NIL) ? S_SO_R : S_SO_DW;
      S_SO_DW:  if (rd_lk_nil) state_next = S_SO_R;
      S_SO_R:   state_next = rh_nil ? S_FIN : S_SO_RH;
      S_SO_RH:  state_next = rd_lk_nil ? S_FIN : S_SO_RW;
      S_SO_RW:  if (rd_lk_nil) state_next = S_FIN;
      S_DN:     state_next = S_WAKE;
      S_FIN:    state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM control outputs
  always_comb begin
    we    = 1'b0;
    w_ptr = cur;
    w_st  = rd_st;
    w_lk  = rd_lk;
    w_dl  = rd_dl;
    r_ptr = rd_lk;
    case (state)
      S_DISP: begin
        if (kind_q == KIND_TICK) r_ptr = delay_head;
        else if (kind_q == KIND_DONE) r_ptr = ready_head;
        else r_ptr = id_ptr;
      end
      S_T_HEAD: begin
        we    = 1'b1;
        w_ptr = tgt;
        if (dec != 16'd0) begin
          w_dl = dec;
        end else begin
          w_st = ST_READY;
          w_dl = 16'd0;
        end
      end
      S_T_WALK: begin
        we    = rd_dl == 16'd0;
        w_ptr = nxt;
        w_st  = ST_READY;
      end
      S_T_CUT: begin
        we   = 1'b1;
        w_st = ST_READY;
        w_lk = NIL;
        w_dl = 16'd0;
      end
      S_APPEND: r_ptr = ready_head;
      S_A_WALK: begin
        we   = rd_lk_nil;
        w_lk = tgt;
      end
      S_WAKE: begin
        r_ptr = delay_head;
        w_ptr = tgt;
        w_lk  = NIL;
        if (sleep_q == 0) begin
          we   = 1'b1;
          w_st = ST_READY;
          w_dl = 16'd0;
        end else if (sleep_q > 0 && dh_nil) begin
          we   = 1'b1;
          w_st = ST_DELAYING;
          w_dl = sleep_q;
        end
      end
      S_D_WALK: begin
        we   = rd_dl > rem;
        w_dl = rd_dl - rem;
      end
      S_D_LINK: begin
        we    = 1'b1;
        w_ptr = tgt;
        w_st  = ST_DELAYING;
        w_lk  = nxt;
        w_dl  = rem;
      end
      S_D_PREV: begin
        we    = 1'b1;
        w_ptr = prev;
        w_st  = ST_DELAYING;
        w_lk  = tgt;
        w_dl  = prev_dl;
      end
      S_S_CHK: begin
        w_ptr = id_ptr;
        w_st  = ST_SUSPENDED;
        if (rd_st == ST_READY) begin
          we    = id_ptr != ready_head;
          r_ptr = ready_head;
        end else if (rd_st == ST_DELAYING) begin
          we    = 1'b1;
          w_dl  = 16'd0;
          r_ptr = delay_head;
        end
      end
      S_U_WALK: begin
        we   = rd_lk == id_ptr;
        w_lk = id_lk;
      end
      S_S_ADD: r_ptr = id_lk;
      S_S_SUM: begin
        we    = 1'b1;
        w_ptr = id_lk;
        w_dl  = sat;
      end
      S_SO_D: r_ptr = cur;
      S_SO_DW, S_SO_RW: begin
        we   = 1'b1;
        w_st = ST_SUSPENDED;
      end
      S_SO_R: r_ptr = ready_head;
      S_SO_RH: begin
        we    = 1'b1;
        w_ptr = ready_head;
        w_lk  = NIL;
      end
      S_DN: begin
        we    = 1'b1;
        w_ptr = ready_head;
        w_st  = ST_SUSPENDED;
        w_lk  = NIL;
      end
      S_FIN: r_ptr = id_ptr;
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fwd_rd   <= we && (waddr == raddr);
    fwd_data <= wdata;
    vld_rd   <= vld[raddr];
    case (state)
      S_IDLE: begin
        if (start) begin
          kind_q  <= cmd.kind;
          id_q    <= cmd.task_id;
          sleep_q <= cmd.sleep_ticks;
        end
      end
      S_DISP: begin
        tgt <= delay_head;
        cur <= delay_head;
      end
      S_T_HEAD: begin
        cur <= tgt;
        nxt <= rd_lk;
      end
      S_T_WALK: begin
        if (rd_dl == 16'd0) begin
          cur <= nxt;
          nxt <= rd_lk;
        end
      end
      S_APPEND: cur <= ready_head;
      S_A_WALK: cur <= rd_lk;
      S_W_CHK:  tgt <= id_ptr;
      S_WAKE: begin
        rem  <= sleep_q;
        prev <= NIL;
        cur  <= delay_head;
      end
      S_D_WALK: begin
        if (rd_dl > rem) begin
          nxt <= cur;
        end else begin
          rem     <= rem - rd_dl;
          prev    <= cur;
          prev_dl <= rd_dl;
          cur     <= rd_lk;
          nxt     <= rd_lk;
        end
      end
      S_S_CHK: begin
        id_lk    <= rd_lk;
        id_dl    <= rd_dl;
        in_delay <= rd_st == ST_DELAYING;
        cur      <= (rd_st == ST_DELAYING) ? delay_head : ready_head;
      end
      S_U_WALK, S_SO_DW, S_SO_RH, S_SO_RW: cur <= rd_lk;
      S_DN: tgt <= ready_head;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready_head <= NIL;
      delay_head <= NIL;
      vld        <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      case (state)
        S_T_CUT:  delay_head <= nxt;
        S_APPEND: if (rh_nil) ready_head <= tgt;
        S_WAKE:   if (sleep_q > 0 && dh_nil) delay_head <= tgt;
        S_D_LINK: if (prev == NIL) delay_head <= tgt;
        S_S_CHK: begin
          if (rd_st == ST_DELAYING && id_ptr == delay_head) delay_head <= rd_lk;
        end
        S_SO_R:   delay_head <= NIL;
        S_DN:     ready_head <= rd_lk;
        default: ;
      endcase
    end
  end

  assign busy              = state != S_IDLE;
  assign done              = state == S_OUT;
  assign result.run_task   = rh_nil ? 4'd0 : 4'(ready_head);
  assign result.run_valid  = !rh_nil;
  assign result.slot_state = id_in ? rd_st : ST_SUSPENDED;

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy)
  `ASSERT_IMPLIES(a_done_in_cmd, clk, rst, done, busy)

endmodule

// ----- dv/delta_list_task_scheduler_core_test.sv -----
`timescale 1ns / 1ps
module delta_list_task_scheduler_core_test;
  import dlts_pkg::*;

  localparam int NTASK = 16;
  localparam logic [4:0] NIL = 5'(NTASK);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cmd_t cmd = '0;
  res_t result;

  delta_list_task_scheduler_core #(.MAX_TASKS(NTASK)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: a private copy of the scheduler's slot table and heads.
  logic [1:0]  sched_status [NTASK];
  logic [4:0]  sched_link   [NTASK];
  logic [15:0] sched_delta  [NTASK];
  logic [4:0]  sched_ready_head;
  logic [4:0]  sched_delay_head;

  res_t expected_words [$];
  int   error_count = 0;
  int   accepted_words = 0;
  int   checked_words = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   kind_seen [8];

  function automatic bit is_slot(logic [4:0] i);
    return i < NIL;
  endfunction

  // Append an already terminated chain to the ready tail.
  function automatic void ready_append(logic [4:0] id);
    logic [4:0] p;
    int n;
    n = 0;
    if (!is_slot(sched_ready_head)) begin
      sched_ready_head = id;
      return;
    end
    p = sched_ready_head;
    while (is_slot(sched_link[p]) && n < NTASK) begin
      p = sched_link[p];
      n++;
    end
    sched_link[p] = id;
  endfunction

  // Put a slot back in play: ready on zero sleep, or into the delta list on a
  // positive sleep, after every entry with an equal or earlier deadline.
  function automatic void wake_task(logic [4:0] id, int s);
    int rem;
    logic [4:0] prev, cur, nxt;
    int n;
    rem = s;
    prev = NIL;
    cur = sched_delay_head;
    nxt = NIL;
    n = 0;
    sched_link[id] = NIL;
    if (s == 0) begin
      sched_status[id] = ST_READY;
      sched_delta[id] = '0;
      ready_append(id);
    end else if (s > 0) begin
      sched_status[id] = ST_DELAYING;
      while (is_slot(cur) && n < NTASK) begin
        if (int'(sched_delta[cur]) > rem) begin
          sched_delta[cur] = 16'(int'(sched_delta[cur]) - rem);
          nxt = cur;
          break;
        end
        rem -= int'(sched_delta[cur]);
        prev = cur;
        cur = sched_link[cur];
        n++;
      end
      sched_delta[id] = 16'(rem);
      sched_link[id] = nxt;
      if (is_slot(prev)) sched_link[prev] = id;
      else sched_delay_head = id;
    end
  endfunction

  function automatic bit unlink_task(bit from_delay, logic [4:0] id);
    logic [4:0] prev, cur;
    int n;
    prev = NIL;
    cur = from_delay ? sched_delay_head : sched_ready_head;
    n = 0;
    while (is_slot(cur) && n < NTASK) begin
      if (cur == id) begin
        if (is_slot(prev)) sched_link[prev] = sched_link[cur];
        else if (from_delay) sched_delay_head = sched_link[cur];
        else sched_ready_head = sched_link[cur];
        return 1'b1;
      end
      prev = cur;
      cur = sched_link[cur];
      n++;
    end
    return 1'b0;
  endfunction

  function automatic void sched_reset();
    for (int i = 0; i < NTASK; i++) begin
      sched_status[i] = ST_SUSPENDED;
      sched_link[i] = NIL;
      sched_delta[i] = '0;
    end
    sched_ready_head = NIL;
    sched_delay_head = NIL;
  endfunction

  // Apply one command word to the predictor and return the result word.
  function automatic res_t sched_apply(cmd_t c);
    res_t r;
    logic [4:0] id, h, last, t, nxt;
    int n;
    int s;
    int unsigned sum;
    id = {1'b0, c.task_id};
    s = int'(c.sleep_ticks);
    n = 0;
    case (c.kind)
      KIND_TICK: begin
        h = sched_delay_head;
        if (is_slot(h)) begin
          if (sched_delta[h] > 0) sched_delta[h]--;
          if (sched_delta[h] == 0) begin
            sched_status[h] = ST_READY;
            last = h;
            while (is_slot(sched_link[last]) && sched_delta[sched_link[last]] == 0
                   && n < NTASK) begin
              last = sched_link[last];
              sched_status[last] = ST_READY;
              n++;
            end
            sched_delay_head = sched_link[last];
            sched_link[last] = NIL;
            ready_append(h);
          end
        end
      end
      KIND_WAKEUP: begin
        if (sched_status[id] == ST_SUSPENDED) wake_task(id, s);
      end
      KIND_SUSPEND: begin
        if (sched_status[id] == ST_READY) begin
          if (id != sched_ready_head) begin
            void'(unlink_task(1'b0, id));
            sched_status[id] = ST_SUSPENDED;
          end
        end else if (sched_status[id] == ST_DELAYING) begin
          nxt = sched_link[id];
          // Fold the removed count into the successor, saturating.
          if (unlink_task(1'b1, id) && is_slot(nxt)) begin
            sum = sched_delta[nxt] + sched_delta[id];
            sched_delta[nxt] = sum > 32'hFFFF ? 16'hFFFF : 16'(sum);
          end
          sched_status[id] = ST_SUSPENDED;
          sched_delta[id] = '0;
        end
      end
      KIND_SUSP_OTHERS: begin
        t = sched_delay_head;
        while (is_slot(t) && n < NTASK) begin
          sched_status[t] = ST_SUSPENDED;
          t = sched_link[t];
          n++;
        end
        sched_delay_head = NIL;
        if (is_slot(sched_ready_head)) begin
          t = sched_link[sched_ready_head];
          n = 0;
          while (is_slot(t) && n < NTASK) begin
            sched_status[t] = ST_SUSPENDED;
            t = sched_link[t];
            n++;
          end
          sched_link[sched_ready_head] = NIL;
        end
      end
      KIND_DONE: begin
        h = sched_ready_head;
        if (is_slot(h)) begin
          sched_status[h] = ST_SUSPENDED;
          sched_ready_head = sched_link[h];
          sched_link[h] = NIL;
          if (s >= 0) wake_task(h, s);
        end
      end
      default: ;
    endcase
    r.run_task = is_slot(sched_ready_head) ? sched_ready_head[3:0] : 4'd0;
    r.run_valid = is_slot(sched_ready_head);
    r.slot_state = sched_status[id];
    return r;
  endfunction

  // Check each strobed result word against the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", result);
        error_count++;
      end else begin
        e = expected_words.pop_front();
        checked_words++;
        if (result.run_task !== e.run_task) begin
          $error("run_task expected %0d got %0d", e.run_task, result.run_task);
          error_count++;
        end
        if (result.run_valid !== e.run_valid) begin
          $error("run_valid expected %0d got %0d", e.run_valid, result.run_valid);
          error_count++;
        end
        if (result.slot_state !== e.slot_state) begin
          $error("slot_state expected %0d got %0d", e.slot_state, result.slot_state);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with neither a command nor a result accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drive one word: idle by the sender's odds, then hold start until taken.
  // start stays up until the next word or the end of the run drives it.
  // The expectation is queued at acceptance, before the result can appear.
  task automatic send_word(cmd_t c, bit typed, res_t typed_res);
    res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = sched_apply(c);
    if (typed && p !== typed_res) begin
      $error("predictor disagrees with typed row: expected %p got %p", typed_res, p);
      error_count++;
    end
    expected_words.push_back(p);
    accepted_words++;
    kind_seen[c.kind]++;
  endtask

  function automatic cmd_t mk(logic [2:0] k, logic [3:0] id, logic signed [15:0] s);
    cmd_t c;
    c.kind = k;
    c.task_id = id;
    c.sleep_ticks = s;
    return c;
  endfunction

  // Random word: mostly wakeups with short sleeps and ticks, so the lists
  // fill and drain; the rest covers big sleeps, negatives and unknown kinds.
  function automatic cmd_t random_word();
    int r;
    logic signed [15:0] s;
    logic [2:0] k;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0: s = 16'($urandom);
      1: s = -16'sd1 - 16'($urandom_range(3));
      2: s = 16'sd0;
      3: s = 16'h7FFF - 16'($urandom_range(2));
      default: s = 16'($urandom_range(6));
    endcase
    if (r < 30) k = KIND_TICK;
    else if (r < 60) k = KIND_WAKEUP;
    else if (r < 75) k = KIND_SUSPEND;
    else if (r < 79) k = KIND_SUSP_OTHERS;
    else if (r < 96) k = KIND_DONE;
    else k = 3'($urandom_range(5, 7));
    return mk(k, 4'($urandom_range(15)), s);
  endfunction

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } stim_row_t;

  stim_row_t directed [] = '{
    // After reset: empty lists, every slot suspended.
    '{mk(KIND_TICK, 4'd0, 16'sd0), 1'b1, '{4'd0, 1'b0, ST_SUSPENDED}},
    '{mk(KIND_DONE, 4'd15, 16'sd0), 1'b1, '{4'd0, 1'b0, ST_SUSPENDED}},
    '{mk(3'd7, 4'd15, 16'sh7FFF), 1'b1, '{4'd0, 1'b0, ST_SUSPENDED}},
    '{mk(KIND_WAKEUP, 4'd3, -16'sd32768), 1'b1, '{4'd0, 1'b0, ST_SUSPENDED}},
    '{mk(KIND_WAKEUP, 4'd15, 16'sd0), 1'b1, '{4'd15, 1'b1, ST_READY}},
    '{mk(KIND_WAKEUP, 4'd0, 16'sd0), 1'b1, '{4'd15, 1'b1, ST_READY}},
    '{mk(KIND_SUSPEND, 4'd15, 16'sd0), 1'b1, '{4'd15, 1'b1, ST_READY}},
    '{mk(KIND_WAKEUP, 4'd15, 16'sd5), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd1, 16'sd3), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd2, 16'sd3), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd4, 16'sh7FFF), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd5, 16'sh7FFF), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd6, 16'sh7FFF), 1'b0, '0},
    '{mk(KIND_SUSPEND, 4'd4, 16'sd0), 1'b0, '0},
    '{mk(KIND_SUSPEND, 4'd1, 16'sd0), 1'b0, '0},
    '{mk(KIND_TICK, 4'd2, 16'sd0), 1'b0, '0},
    '{mk(KIND_TICK, 4'd2, 16'sd0), 1'b0, '0},
    '{mk(KIND_TICK, 4'd2, 16'sd0), 1'b0, '0},
    '{mk(KIND_DONE, 4'd0, 16'sd0), 1'b0, '0},
    '{mk(KIND_DONE, 4'd0, -16'sd1), 1'b0, '0},
    '{mk(KIND_WAKEUP, 4'd8, 16'sd1), 1'b0, '0},
    '{mk(KIND_SUSP_OTHERS, 4'd8, 16'sd0), 1'b0, '0},
    '{mk(KIND_TICK, 4'd6, 16'sd0), 1'b0, '0},
    '{mk(3'd5, 4'd2, 16'sd0), 1'b0, '0},
    '{mk(3'd6, 4'd9, -16'sd2), 1'b0, '0}
  };

  initial begin
    int phase_pct [4];
    phase_pct = '{0, 75, 0, 18};
    sched_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i].c, directed[i].typed, directed[i].r);
    // Walk the idling phases; the receiver cannot stall, so only the
    // sender's gap rate changes, with a stretch of no idling in between.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph];
      for (int i = 0; i < RANDOM_WORDS / 4; i++) send_word(random_word(), 1'b0, '0);
    end
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d words (tick %0d, wakeup %0d, suspend %0d, others %0d, done %0d)",
             accepted_words, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4]);
    $display("checked %0d result words, %0d mismatches", checked_words, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
